/* sv/rrts_pkg.sv */
// Package with shared constants, codes and types of the round-robin tick scheduler.
`default_nettype none
package rrts_pkg;

   localparam int RING_DEPTH_DEF = 16;
   localparam int ID_W = 16;
   localparam int DUR_W = 16;
   localparam int QUANTUM_W = 16;
   localparam int SLICE_W = 17;
   localparam logic [QUANTUM_W-1:0] QUANTUM_RST = 16'd4;
   localparam logic [SLICE_W-1:0] SLICE_MAX = '1;

   typedef enum logic [1:0] {
      EV_IDLE = 2'd0,
      EV_RAN  = 2'd1,
      EV_DONE = 2'd2,
      EV_ROT  = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   typedef struct packed {
      logic accept;
      logic commit;
   } ctl_cmd_type;

endpackage
`default_nettype wire

/* sv/rrts_ctrl.sv */
// Controller state machine of the round-robin tick scheduler.
`default_nettype none
module rrts_ctrl
   import rrts_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  wire logic   rsp_tready,
   output ctl_cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff;
      req_tready = 1'b0;
      cmd = '0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.accept = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule
`default_nettype wire

/* sv/rrts_datapath.sv */
// Datapath of the round-robin tick scheduler: job ring memory, pointers, counters, result register.
`default_nettype none
module rrts_datapath
   import rrts_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEF,
   localparam int PTR_W = $clog2(RING_DEPTH),
   localparam int OCC_W = $clog2(RING_DEPTH + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ctl_cmd_type          cmd,
   input  wire logic                 arrive_valid,
   input  wire logic [ID_W-1:0]      arrive_id,
   input  wire logic [DUR_W-1:0]     arrive_duration,
   input  wire logic                 csr_write,
   input  wire logic [QUANTUM_W-1:0] csr_quantum,
   output logic [1:0]                event_res,
   output logic [ID_W-1:0]           job_id,
   output logic [DUR_W-1:0]          remaining,
   output logic                      overflow,
   output logic [OCC_W-1:0]          queued
);

   typedef struct packed {
      logic [DUR_W-1:0] rem;
      logic [ID_W-1:0]  id;
   } entry_type;

   entry_type ring_mem [RING_DEPTH];
   entry_type mem_q_ff;
   entry_type arrival_ff, arrival_in;
   entry_type head_entry;
   entry_type wr_data;
   logic [PTR_W-1:0] wr_addr;
   logic             wr_en;

   logic [PTR_W-1:0]     head_ptr_ff, head_ptr_in;
   logic [PTR_W-1:0]     tail_ptr_ff, tail_ptr_in;
   logic [OCC_W-1:0]     occ_ff, occ_in;
   logic [SLICE_W-1:0]   slice_ff, slice_in;
   logic [QUANTUM_W-1:0] quantum_ff, quantum_in;
   logic                 bypass_ff, bypass_in;
   logic                 ovf_ff, ovf_in;

   event_type        ev_out_ff, ev_out_in;
   logic [ID_W-1:0]  id_out_ff, id_out_in;
   logic [DUR_W-1:0] rem_out_ff, rem_out_in;
   logic             ovf_out_ff, ovf_out_in;
   logic [OCC_W-1:0] occ_out_ff, occ_out_in;

   logic can_push;
   logic busy;
   logic [SLICE_W-1:0] slice_inc;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      next_ptr = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign can_push = (occ_ff != OCC_W'(RING_DEPTH));
   assign busy = (occ_ff != '0);
   assign head_entry = bypass_ff ? arrival_ff : mem_q_ff;
   assign slice_inc = (slice_ff == SLICE_MAX) ? slice_ff : slice_ff + 1'b1;

   always_comb begin
      head_ptr_in = head_ptr_ff;
      tail_ptr_in = tail_ptr_ff;
      occ_in = occ_ff;
      slice_in = slice_ff;
      quantum_in = csr_write ? csr_quantum : quantum_ff;
      bypass_in = bypass_ff;
      ovf_in = ovf_ff;
      arrival_in = arrival_ff;
      ev_out_in = ev_out_ff;
      id_out_in = id_out_ff;
      rem_out_in = rem_out_ff;
      ovf_out_in = ovf_out_ff;
      occ_out_in = occ_out_ff;
      wr_en = 1'b0;
      wr_addr = tail_ptr_ff;
      wr_data = arrival_in;

      if (cmd.accept) begin
         arrival_in.id = arrive_id;
         arrival_in.rem = arrive_duration;
         wr_data = arrival_in;
         bypass_in = arrive_valid && !busy;
         ovf_in = arrive_valid && !can_push;
         if (arrive_valid && can_push) begin
            wr_en = 1'b1;
            tail_ptr_in = next_ptr(tail_ptr_ff);
            occ_in = occ_ff + 1'b1;
         end
      end

      if (cmd.commit) begin
         ev_out_in = EV_IDLE;
         id_out_in = '0;
         rem_out_in = '0;
         ovf_out_in = ovf_ff;
         bypass_in = 1'b0;
         if (busy) begin
            id_out_in = head_entry.id;
            if (slice_ff < {1'b0, quantum_ff}) begin
               slice_in = slice_inc;
               if (head_entry.rem != '0) begin
                  ev_out_in = EV_RAN;
                  rem_out_in = head_entry.rem - 1'b1;
                  wr_en = 1'b1;
                  wr_addr = head_ptr_ff;
                  wr_data.id = head_entry.id;
                  wr_data.rem = rem_out_in;
               end else begin
                  ev_out_in = EV_DONE;
                  head_ptr_in = next_ptr(head_ptr_ff);
                  occ_in = occ_ff - 1'b1;
               end
            end else begin
               ev_out_in = EV_ROT;
               rem_out_in = head_entry.rem;
               wr_en = 1'b1;
               wr_addr = tail_ptr_ff;
               wr_data = head_entry;
               head_ptr_in = next_ptr(head_ptr_ff);
               tail_ptr_in = next_ptr(tail_ptr_ff);
               slice_in = '0;
            end
         end else begin
            slice_in = slice_inc;
         end
         occ_out_in = occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
      mem_q_ff <= ring_mem[head_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ptr_ff <= '0;
         tail_ptr_ff <= '0;
         occ_ff <= '0;
         slice_ff <= '0;
         quantum_ff <= QUANTUM_RST;
         bypass_ff <= 1'b0;
      end else begin
         head_ptr_ff <= head_ptr_in;
         tail_ptr_ff <= tail_ptr_in;
         occ_ff <= occ_in;
         slice_ff <= slice_in;
         quantum_ff <= quantum_in;
         bypass_ff <= bypass_in;
      end
   end

   always_ff @(posedge clock) begin
      arrival_ff <= arrival_in;
      ovf_ff <= ovf_in;
      ev_out_ff <= ev_out_in;
      id_out_ff <= id_out_in;
      rem_out_ff <= rem_out_in;
      ovf_out_ff <= ovf_out_in;
      occ_out_ff <= occ_out_in;
   end

   assign event_res = ev_out_ff;
   assign job_id = id_out_ff;
   assign remaining = rem_out_ff;
   assign overflow = ovf_out_ff;
   assign queued = occ_out_ff;

endmodule
`default_nettype wire

/* sv/round_robin_tick_scheduler.sv */
// Top level of the round-robin tick scheduler.
//
// Each transaction on the req_ channel is one scheduler tick. It may carry one arriving
// job (flag in req_tuser, id and duration in req_tdata) that is appended to a ring of
// RING_DEPTH jobs, or dropped with the overflow flag set when the ring is full. The head
// job, if any, then runs, finishes or is rotated to the tail, and exactly one transaction on the
// rsp_ channel reports the event, the job, its remaining ticks and the ring occupancy.
// The csr_ channel writes the time slice length (quantum); the user must write it only while no
// tick is in flight, which the block itself does not enforce.
// A tick's result is registered: the accepting edge writes the arrival and reads the head
// entry from the ring memory's single read port; in the execute state the controller acts on
// the head, writes it back and loads the result. A new tick is accepted only once the previous
// one has left the execute state. The result waits in an output register; the
// next tick is accepted while it waits, and its result is held back until the receiver
// takes the previous one.
// Reset empties the ring, clears the slice counter and sets the quantum to 4; no channel
// accepts a transaction while reset is high. The ring memory is not cleared; its entries
// are only read once written.
`default_nettype none
module round_robin_tick_scheduler
   import rrts_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEF,
   localparam int OCC_W = $clog2(RING_DEPTH + 1),
   localparam int RSP_BITS = ID_W + DUR_W + 1 + OCC_W,
   localparam int RSP_W = ((RSP_BITS + 7) / 8) * 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // arrive_id, arrive_duration
   input  wire logic [31:0]          req_tdata,
   // arrive_valid
   input  wire logic [0:0]           req_tuser,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // job_id, remaining, overflow, queued, zero fill
   output logic [RSP_W-1:0]          rsp_tdata,
   // event_res
   output logic [1:0]                rsp_tuser,
   input  wire logic                 csr_tvalid,
   output logic                      csr_tready,
   // quantum
   input  wire logic [QUANTUM_W-1:0] csr_tdata
);

   ctl_cmd_type      cmd;
   logic [ID_W-1:0]  job_id;
   logic [DUR_W-1:0] remaining;
   logic             overflow;
   logic [OCC_W-1:0] queued;

   assign csr_tready = !reset;

   rrts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   rrts_datapath #(
      .RING_DEPTH (RING_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .arrive_valid    (req_tuser[0]),
      .arrive_id       (req_tdata[ID_W-1:0]),
      .arrive_duration (req_tdata[ID_W+DUR_W-1:ID_W]),
      .csr_write       (csr_tvalid && csr_tready),
      .csr_quantum     (csr_tdata),
      .event_res       (rsp_tuser),
      .job_id          (job_id),
      .remaining       (remaining),
      .overflow        (overflow),
      .queued          (queued)
   );

   assign rsp_tdata = RSP_W'({queued, overflow, remaining, job_id});

endmodule
`default_nettype wire

/* sv/rrts_checker.sv */
// Port checker of the round-robin tick scheduler and its bind statement.
`default_nettype none
module rrts_checker
   import rrts_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEF,
   localparam int OCC_W = $clog2(RING_DEPTH + 1),
   localparam int RSP_BITS = ID_W + DUR_W + 1 + OCC_W,
   localparam int RSP_W = ((RSP_BITS + 7) / 8) * 8
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [RSP_W-1:0] rsp_tdata,
   input wire logic [1:0]       rsp_tuser
);

   logic [OCC_W-1:0] queued;
   logic             overflow;

   assign queued = rsp_tdata[ID_W+DUR_W+1 +: OCC_W];
   assign overflow = rsp_tdata[ID_W+DUR_W];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Result transaction changed while stalled.");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EV_IDLE |-> rsp_tdata[ID_W+DUR_W-1:0] == '0 && queued == '0)
      else $error("Idle tick reports a job or a nonempty ring.");

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EV_DONE |-> rsp_tdata[ID_W+DUR_W-1:ID_W] == '0)
      else $error("Finished job reports remaining ticks.");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && overflow |-> queued >= OCC_W'(RING_DEPTH - 1))
      else $error("Job dropped while the ring had room.");

   a_busy_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == EV_RAN || rsp_tuser == EV_ROT) |-> queued != '0)
      else $error("Head job acted on with an empty ring.");

endmodule

bind round_robin_tick_scheduler rrts_checker #(
   .RING_DEPTH (RING_DEPTH)
) u_rrts_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
